>>> rtl/led_frm_pkg.sv
// shared constants for the led strip color frame builder
`default_nettype none

package led_frm_pkg;

  localparam int unsigned NUM_CHANNELS = 3;
  localparam int unsigned COLOR_W      = 8;
  localparam int unsigned ROW_W        = NUM_CHANNELS * COLOR_W;
  localparam int unsigned BRIGHT_W     = 5;

  localparam logic [7:0]          START_BYTE   = 8'h00;
  localparam logic [7:0]          END_BYTE     = 8'hFF;
  localparam logic [7:0]          HDR_MARK     = 8'hE0;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'd10;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_LEDS  = 2'd2;
  localparam logic [1:0] S_END   = 2'd3;

  // byte slot inside a four byte group
  localparam logic [1:0] SLOT_HDR   = 2'd0;
  localparam logic [1:0] SLOT_BLUE  = 2'd1;
  localparam logic [1:0] SLOT_GREEN = 2'd2;
  localparam logic [1:0] SLOT_RED   = 2'd3;

  // channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/led_strip_color_frame_builder_core.sv
// top level: led strip color frame builder, sample in, two-wire frame bytes out
//
// input channel: one beat carries an 8-bit pot sample plus the channel and led
// button events; the channel event wins when both are set
// the beat updates the selected channel of the working color and copies the
// working color into the selected led's row in the color memory (same cycle)
// result channel: 8 + 4*NUM_LEDS beats per input beat (20 for three leds):
// four 0x00 start bytes, then per led 0xE0|brightness, blue, green, red,
// then four 0xFF end bytes; out_last_byte marks the final end byte
// the accepted beat moves the sequencer out of idle, then the first start byte
// enters the output register; no new input beat is taken until the last end
// byte is loaded; with no stall, one output byte per cycle is formed by the
// shared byte unit and the single color memory read port (one row read per led)
// in_ready is high only while the sequencer is idle; it rises while the last
// end byte still waits in the output register
// receiver stall: the output register holds its beat and the sequencer waits
// reset (rst_n low, synchronous): brightness 10, colors zero, both indexes zero,
// all rows read as zero until first written; no clearing pass is needed
// cfg_we writes the brightness; only use while idle
`default_nettype none

module led_strip_color_frame_builder_core
  import led_frm_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [BRIGHT_W-1:0] cfg_wdata,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_adc_sample,
  input  wire logic                in_next_channel,
  input  wire logic                in_next_led,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_frame_byte,
  output logic                     out_last_byte
);

  localparam int unsigned LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);

  // control and working state
  logic [1:0]          state_r, state_nxt;
  logic [1:0]          slot_r, slot_nxt;
  logic [LED_W-1:0]    led_cnt_r, led_cnt_nxt;
  logic [1:0]          chan_idx_r, chan_idx_nxt;
  logic [LED_W-1:0]    led_idx_r, led_idx_nxt;
  logic [BRIGHT_W-1:0] bright_r;
  logic [COLOR_W-1:0]  wc_r [NUM_CHANNELS];
  logic [COLOR_W-1:0]  wc_nxt [NUM_CHANNELS];

  // color memory, one row per led: {blue, green, red}
  logic [ROW_W-1:0]    mem_r [NUM_LEDS];
  logic [NUM_LEDS-1:0] row_vld_r;
  logic [ROW_W-1:0]    rd_r;
  logic                rd_vld_r;
  logic [ROW_W-1:0]    rd_color;

  // output register
  logic                out_valid_r;
  logic [7:0]          out_byte_r, byte_nxt;
  logic                out_last_r, last_nxt;

  logic in_acc;
  logic load;
  logic rd_en;

  assign in_ready       = (state_r == S_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  // a new byte enters the output register when it is empty or being drained
  assign load     = (state_r != S_IDLE) && (!out_valid_r || out_ready);
  assign rd_en    = load && (state_r == S_LEDS) && (slot_r == SLOT_HDR);
  assign rd_color = rd_vld_r ? rd_r : '0;

  // index advance and working color update
  always_comb begin
    chan_idx_nxt = chan_idx_r;
    led_idx_nxt  = led_idx_r;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      wc_nxt[i] = wc_r[i];
    end
    if (in_acc) begin
      if (in_next_channel) begin
        chan_idx_nxt = (chan_idx_r == CH_BLUE) ? CH_RED : chan_idx_r + 2'd1;
      end else if (in_next_led) begin
        led_idx_nxt = (led_idx_r == LED_LAST) ? '0 : led_idx_r + LED_W'(1);
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (chan_idx_nxt == 2'(i)) begin
          wc_nxt[i] = in_adc_sample;
        end
      end
    end
  end

  // shared byte unit: sequencer position picks the next frame byte
  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    led_cnt_nxt = led_cnt_r;
    byte_nxt    = START_BYTE;
    last_nxt    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt   = S_START;
          slot_nxt    = SLOT_HDR;
          led_cnt_nxt = '0;
        end
      end
      S_START: begin
        byte_nxt = START_BYTE;
        if (load) begin
          slot_nxt = slot_r + 2'd1;
          if (slot_r == SLOT_RED) begin
            state_nxt = S_LEDS;
          end
        end
      end
      S_LEDS: begin
        case (slot_r)
          SLOT_HDR:   byte_nxt = HDR_MARK | {3'b000, bright_r};
          SLOT_BLUE:  byte_nxt = rd_color[3*COLOR_W-1:2*COLOR_W];
          SLOT_GREEN: byte_nxt = rd_color[2*COLOR_W-1:COLOR_W];
          default:    byte_nxt = rd_color[COLOR_W-1:0];
        endcase
        if (load) begin
          slot_nxt = slot_r + 2'd1;
          if (slot_r == SLOT_RED) begin
            if (led_cnt_r == LED_LAST) begin
              state_nxt = S_END;
            end else begin
              led_cnt_nxt = led_cnt_r + LED_W'(1);
            end
          end
        end
      end
      S_END: begin
        byte_nxt = END_BYTE;
        last_nxt = (slot_r == SLOT_RED);
        if (load) begin
          slot_nxt = slot_r + 2'd1;
          if (slot_r == SLOT_RED) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= SLOT_HDR;
      led_cnt_r   <= '0;
      chan_idx_r  <= CH_RED;
      led_idx_r   <= '0;
      bright_r    <= BRIGHT_RESET;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wc_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      slot_r     <= slot_nxt;
      led_cnt_r  <= led_cnt_nxt;
      chan_idx_r <= chan_idx_nxt;
      led_idx_r  <= led_idx_nxt;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wc_r[i] <= wc_nxt[i];
      end
      if (cfg_we) begin
        bright_r <= cfg_wdata;
      end
      if (in_acc) begin
        row_vld_r[led_idx_nxt] <= 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // color memory write and registered read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_r[led_idx_nxt] <= {wc_nxt[CH_BLUE], wc_nxt[CH_GREEN], wc_nxt[CH_RED]};
    end
    if (rd_en) begin
      rd_r <= mem_r[led_cnt_r];
    end
  end

  // row valid flag follows the read so unwritten rows read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= row_vld_r[led_cnt_r];
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last_nxt;
    end
  end

  // the last beat of a frame is always an end byte
  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte) |-> (out_frame_byte == END_BYTE))
    else $error("last beat is not an end byte");

  // once an item is taken the block stays busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready high right after accept");

  // led counter stays within the strip
  a_led_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (led_cnt_r <= LED_LAST) && (led_idx_r <= LED_LAST))
    else $error("led counter out of range");

  // returning to idle happens only as the final end byte is loaded
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_END) && (state_nxt == S_IDLE)) |=> (out_valid && out_last_byte))
    else $error("frame ended without last beat");

endmodule

`default_nettype wire

>>> dv/tb.sv
// testbench for the led strip color frame builder: random samples, frame bytes checked
module tb;
  import led_frm_pkg::*;

  localparam int unsigned NUM_LEDS   = 3;
  localparam int unsigned EDGE_BYTES = 4;
  localparam int unsigned LONG_HOLD  = 160;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_HALF} rx_pattern_t;

  // keeps its own copy of the colors and builds the frame each sample should cause
  class led_frame_scoreboard;
    logic [7:0]          work_rgb [NUM_CHANNELS];
    logic [7:0]          led_rgb [NUM_LEDS][NUM_CHANNELS];
    logic [1:0]          sel_ch;
    int unsigned         sel_led;
    logic [BRIGHT_W-1:0] brightness;
    frame_beat_t         frame_bytes_due[$];
    int unsigned         mismatches;

    function new();
      foreach (work_rgb[c]) work_rgb[c] = '0;
      foreach (led_rgb[l, c]) led_rgb[l][c] = '0;
      sel_ch     = CH_RED;
      sel_led    = 0;
      brightness = BRIGHT_RESET;
      mismatches = 0;
    endfunction

    function void add_beat(input logic [7:0] data, input logic last);
      frame_beat_t beat;
      beat.data = data;
      beat.last = last;
      frame_bytes_due.push_back(beat);
    endfunction

    // accepted input beat: update the colors, queue the whole frame
    function void apply_sample(input logic [7:0] level, input logic chan_evt,
                               input logic led_evt);
      if (chan_evt)
        sel_ch = (sel_ch == CH_BLUE) ? CH_RED : sel_ch + 2'd1;
      else if (led_evt)
        sel_led = (sel_led + 1) % NUM_LEDS;
      work_rgb[sel_ch] = level;
      foreach (work_rgb[c]) led_rgb[sel_led][c] = work_rgb[c];
      for (int e = 0; e < EDGE_BYTES; e++) add_beat(START_BYTE, 1'b0);
      for (int l = 0; l < NUM_LEDS; l++) begin
        add_beat(HDR_MARK | {3'b000, brightness}, 1'b0);
        add_beat(led_rgb[l][CH_BLUE], 1'b0);
        add_beat(led_rgb[l][CH_GREEN], 1'b0);
        add_beat(led_rgb[l][CH_RED], 1'b0);
      end
      for (int e = 0; e < EDGE_BYTES; e++) add_beat(END_BYTE, e == EDGE_BYTES - 1);
    endfunction

    // accepted result beat against the oldest byte still due
    function void match_byte(input logic [7:0] data, input logic last);
      frame_beat_t want;
      if (frame_bytes_due.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("extra beat: byte %02h last %0b, nothing due", data, last);
        mismatches++;
        return;
      end
      want = frame_bytes_due.pop_front();
      if (want.data !== data || want.last !== last) begin
        if (mismatches < REPORT_MAX)
          $display("mismatch: byte %02h last %0b, expected byte %02h last %0b",
                   data, last, want.data, want.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [BRIGHT_W-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_adc_sample = '0;
  logic                in_next_channel = 1'b0;
  logic                in_next_led = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_frame_byte;
  logic                out_last_byte;
  bit                  want_long_hold = 1'b0;

  led_frame_scoreboard board = new();

  always #2 clk = ~clk;

  led_strip_color_frame_builder_core #(
    .NUM_LEDS(NUM_LEDS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_adc_sample  (in_adc_sample),
    .in_next_channel(in_next_channel),
    .in_next_led    (in_next_led),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

  // result beats are checked before the input beat of the same edge is noted
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.match_byte(out_frame_byte, out_last_byte);
    if (rst_n && in_valid && in_ready)
      board.apply_sample(in_adc_sample, in_next_channel, in_next_led);
  end

  // receiver: stretches of a random stall pattern, one long hold when asked
  initial begin : receiver
    bit          long_hold_done;
    rx_pattern_t pattern;
    int unsigned stretch;
    long_hold_done = 1'b0;
    forever begin
      if (want_long_hold && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      pattern = rx_pattern_t'($urandom_range(0, 3));
      stretch = $urandom_range(10, 150);
      for (int k = 0; k < stretch; k++) begin
        case (pattern)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= (k % 4 == 0);
          default:   out_ready <= (k >= stretch / 2);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_sample(input logic [7:0] level, input logic chan_evt,
                             input logic led_evt);
    in_valid        <= 1'b1;
    in_adc_sample   <= level;
    in_next_channel <= chan_evt;
    in_next_led     <= led_evt;
    do @(posedge clk); while (!in_ready);
  endtask

  // random samples in bursts; steady leaves out the gaps
  task automatic send_random(input int unsigned count, input bit steady);
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    int unsigned pick;
    logic [7:0]  level;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) begin
        pick  = $urandom_range(0, 9);
        level = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        // half plain samples, the rest channel, led or both buttons
        pick = $urandom_range(0, 7);
        send_sample(level, pick >= 4 && pick != 6, pick >= 6);
        left--;
      end
      gap = steady ? 0 : $urandom_range(0, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // one edge first so the frame of the last accepted sample is already queued
  task automatic drain_frames();
    @(posedge clk);
    while (board.frame_bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_brightness(input logic [BRIGHT_W-1:0] level);
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.brightness = level;
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset brightness, channel and led walks with wrap, both buttons at once
    send_sample(8'h00, 1'b0, 1'b0);
    send_sample(8'hFF, 1'b0, 1'b0);
    send_sample(8'h5A, 1'b1, 1'b0);
    send_sample(8'hA5, 1'b1, 1'b1);
    send_sample(8'h3C, 1'b0, 1'b1);
    send_sample(8'hC3, 1'b1, 1'b0);
    send_sample(8'h81, 1'b0, 1'b1);
    send_sample(8'h7E, 1'b0, 1'b1);
    send_sample(8'h01, 1'b1, 1'b1);
    send_sample(8'h80, 1'b1, 1'b1);
    in_valid <= 1'b0;
    drain_frames();

    set_brightness('1);
    send_sample(8'hFF, 1'b1, 1'b0);
    send_sample(8'h00, 1'b0, 1'b1);
    send_sample(8'hAA, 1'b0, 1'b0);
    send_sample(8'h55, 1'b1, 1'b1);
    send_sample(8'hFF, 1'b0, 1'b1);
    send_sample(8'h00, 1'b1, 1'b0);
    in_valid <= 1'b0;
    drain_frames();

    set_brightness('0);
    send_sample(8'h12, 1'b0, 1'b1);
    send_sample(8'hFE, 1'b1, 1'b0);
    send_sample(8'h7F, 1'b0, 1'b0);
    send_sample(8'h80, 1'b0, 1'b1);
    in_valid <= 1'b0;

    // long receiver hold early in the random part, input keeps offering
    for (int ph = 0; ph < 7; ph++) begin
      drain_frames();
      set_brightness(BRIGHT_W'($urandom_range(0, 31)));
      if (ph == 0) want_long_hold <= 1'b1;
      send_random(40, ph == 3);
    end
    drain_frames();
    repeat (30) @(posedge clk);

    if (board.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
